// File: hdl/b64e_pkg.sv
// Shared types, constants and the character lookup for the base64 stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam int         QUEUE_DEPTH = 2;

   // One complete 24-bit group waiting to be turned into four characters.
   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  pad_count;  // number of trailing '=' characters, 0 to 2
      logic        final_grp;  // the group closes the message
   } group_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic      valid;
      group_type entry;
   } queue_head_type;

   // Front-end status, used for checking.
   typedef struct packed {
      logic [1:0] pending_count;
   } front_status_type;

   // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [7:0] sextet_char(input logic [5:0] value);
      logic [7:0] v;
      logic [7:0] result;
      v = {2'b00, value};
      if (value < 6'd26) begin
         result = 8'h41 + v;
      end else if (value < 6'd52) begin
         result = 8'h61 + v - 8'd26;
      end else if (value < 6'd62) begin
         result = 8'h30 + v - 8'd52;
      end else if (value == 6'd62) begin
         result = 8'h2B;
      end else begin
         result = 8'h2F;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: hdl/base64_stream_encoder_top.sv
// Top level of the streaming base64 encoder: front end, group queue and back end.
`timescale 1ns / 1ps
`default_nettype none

// The encoder takes a message one byte per transfer on the req_ channel, with
// req_end_of_message marking the final byte, and gives the standard base64 text
// one character per transfer on the rsp_ channel. Every third byte completes a
// 24-bit group, which comes out as four characters, most significant sextet
// first; a message that ends on one or two bytes of a group gives two or three
// characters followed by '=' padding, so every group is four characters long.
// The final character of the message carries rsp_last_char. The back end gives
// out a group as four characters, one at a time through its output register,
// so the sustained input rate is three bytes for every four characters. The
// front end accepts a byte in every cycle while the two-entry group queue has
// room, so short bursts go in at one byte per cycle, and a result waiting at
// the output does not stop bytes from being taken.
module base64_stream_encoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_message,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_char
);
   import b64e_pkg::*;

   logic             push;
   group_type        push_entry;
   logic             queue_full;
   logic             pop;
   queue_head_type   head;
   front_status_type front_status;

   // Position of the next character within its group, kept for checking.
   logic [1:0]       chk_pos_ff, chk_pos_in;

   b64e_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .push               (push),
      .push_entry         (push_entry),
      .queue_full         (queue_full),
      .status             (front_status)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   assign chk_pos_in = (rsp_valid && rsp_ready) ? chk_pos_ff + 2'd1 : chk_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_pos_ff <= 2'd0;
      end else begin
         chk_pos_ff <= chk_pos_in;
      end
   end

   // The end of a message always leaves the front end with nothing held.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_message) |=> (front_status.pending_count == 2'd0))
      else $error("pending bytes left after the end of a message");

   // The final character is always the fourth of its group.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> (chk_pos_ff == 2'd3))
      else $error("final character not at the end of a group");

   // Padding only ever fills the third or fourth place of a group.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_char == PAD_CHAR)) |-> (chk_pos_ff == 2'd2 || chk_pos_ff == 2'd3))
      else $error("padding in the first half of a group");

   // A group is never pushed while the queue is full.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("group pushed into a full queue");

endmodule

`default_nettype wire

// File: hdl/b64e_front.sv
// Front end: accepts message bytes, holds partial groups and forms complete groups.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_end_of_message,
   output logic                           push,
   output b64e_pkg::group_type            push_entry,
   input  wire logic                      queue_full,
   output b64e_pkg::front_status_type     status
);
   import b64e_pkg::*;

   logic [15:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign status.pending_count = count_ff;

   always_comb begin
      held_in          = held_ff;
      count_in         = count_ff;
      push             = 1'b0;
      push_entry.group     = {held_ff, req_data_byte};
      push_entry.pad_count = 2'd0;
      push_entry.final_grp = req_end_of_message;
      if (count_ff >= 2'd2) begin
         push_entry.group     = {held_ff, req_data_byte};
         push_entry.pad_count = 2'd0;
      end else if (count_ff == 2'd1) begin
         push_entry.group     = {held_ff[7:0], req_data_byte, 8'h00};
         push_entry.pad_count = 2'd1;
      end else begin
         push_entry.group     = {req_data_byte, 16'h0000};
         push_entry.pad_count = 2'd2;
      end
      if (accept) begin
         if (count_ff >= 2'd2 || req_end_of_message) begin
            push     = 1'b1;
            held_in  = 16'h0000;
            count_in = 2'd0;
         end else begin
            held_in  = {held_ff[7:0], req_data_byte};
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 16'h0000;
         count_ff <= 2'd0;
      end else begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/b64e_queue.sv
// Short queue of complete groups between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire b64e_pkg::group_type     push_entry,
   output logic                         full,
   input  wire logic                    pop,
   output b64e_pkg::queue_head_type     head
);
   import b64e_pkg::*;

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);

   group_type                entries_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]        fill_ff, fill_in;

   assign full       = (fill_ff == (PtrWidth+1)'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == (PtrWidth)'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + (PtrWidth)'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == (PtrWidth)'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + (PtrWidth)'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + (PtrWidth+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (PtrWidth+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/b64e_back.sv
// Back end: turns each queued group into four characters, one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire b64e_pkg::queue_head_type head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_out_char,
   output logic                         rsp_last_char
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic [5:0] sextet;
   logic       is_pad;

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   // The output register may take a new character when empty or being drained.
   assign load = !valid_ff || rsp_ready;
   assign pop  = load && head.valid && (idx_ff == 2'd3);

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = head.entry.group[23:18];
         2'd1:    sextet = head.entry.group[17:12];
         2'd2:    sextet = head.entry.group[11:6];
         default: sextet = head.entry.group[5:0];
      endcase
      is_pad = ((idx_ff == 2'd3) && (head.entry.pad_count != 2'd0)) ||
               ((idx_ff == 2'd2) && (head.entry.pad_count == 2'd2));

      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head.valid;
         char_in  = is_pad ? PAD_CHAR : sextet_char(sextet);
         last_in  = head.entry.final_grp && (idx_ff == 2'd3);
         if (head.valid) begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

// File: bench/tb_base64_stream_encoder_top.sv
// Self-checking testbench for the streaming base64 encoder top level.
`timescale 1ns / 1ps

// The bench feeds whole messages, one byte per transfer, into the encoder and
// checks every character that comes out against its own encoder model. The
// model is advanced on each accepted byte and queues the four characters that
// a completed or closed group must produce. The monitor pops one expectation
// per character transfer and compares both fields.
//
// The run has four parts:
//    - a short directed set of messages covering the padding cases;
//    - random messages with a busy sender and a lazy receiver;
//    - random messages with a lazy sender and a busy receiver;
//    - random messages with no idling, during which the receiver holds off
//      for a long stretch, so the group queue fills and the input stalls.
// A watchdog ends the run if no transfer happens on either channel for too
// long.
module tb_base64_stream_encoder_top;

   import b64e_pkg::*;

   localparam int QUIET_LIMIT    = 4000;  // cycles with no transfer before giving up
   localparam int LONG_HOLD      = 300;   // length of the receiver's long hold-off
   localparam int SETTLE_CYCLES  = 8;     // quiet cycles allowed at the very end
   localparam int REPORT_LIMIT   = 10;    // mismatches printed in full

   // Standard alphabet packed as a string, first character in the top byte.
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [7:0] data;
      logic       eom;
   } msg_byte_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte      = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready          = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;

   // Bytes waiting to be offered, and characters the encoder still owes us.
   msg_byte_type  pending_bytes_q[$];
   text_char_type expected_chars_q[$];

   // Model state: bytes held towards the next group.
   logic [15:0] held_bytes = 16'h0000;
   logic [1:0]  held_count = 2'd0;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   logic long_hold_armed = 1'b0;
   int mismatch_count    = 0;
   int quiet_cycles      = 0;

   base64_stream_encoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Encoder model
   // ---------------------------------------------------------------------

   // Queues the four characters of a left-aligned 24-bit group. The first
   // data_chars are alphabet characters, the rest are padding; the fourth
   // carries the end-of-text flag when the group closes the message.
   task automatic queue_group_chars(input logic [23:0] grp, input int data_chars,
                                    input logic closes);
      text_char_type c;
      logic [5:0] sextet;
      for (int k = 0; k < 4; k++) begin
         sextet = grp[23 - 6*k -: 6];
         c.ch   = (k < data_chars) ? ALPHABET[8*(63 - sextet) +: 8] : PAD_CHAR;
         c.last = closes && (k == 3);
         expected_chars_q.insert(expected_chars_q.size(), c);
      end
   endtask

   // Advances the model by one accepted byte.
   task automatic encode_byte(input logic [7:0] b, input logic eom);
      if (held_count >= 2'd2) begin
         // A third byte always completes a group, whether or not it ends the
         // message; a message ending here gets no padding.
         queue_group_chars({held_bytes, b}, 4, eom);
         held_bytes = 16'h0000;
         held_count = 2'd0;
      end else if (eom) begin
         // A partial group is pushed up to the top of the 24-bit word.
         if (held_count == 2'd0) begin
            queue_group_chars({b, 16'h0000}, 2, 1'b1);
         end else begin
            queue_group_chars({held_bytes[7:0], b, 8'h00}, 3, 1'b1);
         end
         held_bytes = 16'h0000;
         held_count = 2'd0;
      end else begin
         held_bytes = {held_bytes[7:0], b};
         held_count = held_count + 2'd1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Byte driver
   // ---------------------------------------------------------------------

   // The slot is free when nothing is offered or the current byte has just
   // been taken. A new byte is then offered unless the sender chooses to idle.
   // Each output gets at most one assignment per edge.
   always @(posedge clock) begin : byte_driver
      msg_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_end_of_message);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pending_bytes_q.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= nxt.data;
               req_end_of_message <= nxt.eom;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Character monitor and receiver
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input text_char_type want,
                                  input text_char_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%t: %s: expected char 8'h%02h last %0b, got char 8'h%02h last %0b",
                  $realtime, what, want.ch, want.last, got.ch, got.last);
      end
   endtask

   // Each character transfer is checked against the oldest expectation. The
   // receiver's ready is drawn at random, except during the single long
   // hold-off, whose length is counted here.
   always @(posedge clock) begin : char_monitor
      text_char_type want;
      text_char_type got;
      int            hold_left;
      bit            hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.ch   = rsp_out_char;
            got.last = rsp_last_char;
            if (expected_chars_q.size() == 0) begin
               want.ch   = 8'h00;
               want.last = 1'b0;
               report_mismatch("character with nothing expected", want, got);
            end else begin
               want = expected_chars_q.pop_front();
               if (got.ch !== want.ch) begin
                  report_mismatch("wrong character", want, got);
               end else if (got.last !== want.last) begin
                  report_mismatch("wrong end-of-text flag", want, got);
               end
            end
         end
         if (long_hold_armed && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------

   // Any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_base64_stream_encoder_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] b, input logic eom);
      msg_byte_type m;
      m.data = b;
      m.eom  = eom;
      pending_bytes_q.insert(pending_bytes_q.size(), m);
   endtask

   // Queues random messages until about byte_total bytes have been added.
   // Lengths are mostly short so that every partial-group ending turns up
   // often; byte values lean a little towards all-zeros and all-ones.
   task automatic add_random_messages(input int byte_total);
      int added;
      int len;
      int pick;
      logic [7:0] b;
      added = 0;
      while (added < byte_total) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(7);
            b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            add_byte(b, i == len - 1);
         end
         added += len;
      end
   endtask

   // Waits until every queued byte has been taken and every owed character
   // has come out. The check is made between edges, once the driver's and
   // monitor's updates for the edge have all settled.
   task automatic wait_until_drained();
      while (pending_bytes_q.size() != 0 || req_valid || expected_chars_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed messages: single bytes at both extremes (two characters and
      // two pads), two-byte messages (one pad), three-byte messages that end
      // on a full group without padding, and longer ones that run through
      // complete groups before ending on a partial one.
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'h4D, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h6E, 1'b0);
      add_byte(8'h20, 1'b1);
      add_byte(8'hFB, 1'b0);
      add_byte(8'hEF, 1'b0);
      add_byte(8'hBE, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h10, 1'b0);
      add_byte(8'h83, 1'b0);
      add_byte(8'hFF, 1'b1);
      wait_until_drained();

      // Busy sender, lazy receiver.
      sender_idle_pct   = 21;
      receiver_idle_pct = 81;
      add_random_messages(70);
      wait_until_drained();

      // Lazy sender, busy receiver.
      sender_idle_pct   = 81;
      receiver_idle_pct = 21;
      add_random_messages(70);
      wait_until_drained();

      // Full rate on both sides. The receiver's long hold-off starts with
      // plenty of bytes queued, so the encoder backs up to its input.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      add_random_messages(60);
      long_hold_armed <= 1'b1;
      wait_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars_q.size() == 0) begin
         $display("tb_base64_stream_encoder_top passed");
      end else begin
         $display("tb_base64_stream_encoder_top failed");
      end
      $finish;
   end

endmodule
